FILE: src/telnet_option_line_parser_assert.svh
// Assertion macros for the telnet option line parser.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef TELNET_OPTION_LINE_PARSER_ASSERT_SVH
`define TELNET_OPTION_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TOLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TOLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tolp_pkg.sv
// Shared types, telnet codes and helpers for the telnet option line parser.
// No dependencies.
package tolp_pkg;

  localparam int LINE_SIZE   = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RES     = 4;
  localparam int NUM_SLOTS   = 6;
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int SLOT_CNT_W  = $clog2(NUM_SLOTS + 1);

  // Telnet codes and special bytes
  localparam logic [7:0] C_IAC      = 8'd255;
  localparam logic [7:0] C_DONT     = 8'd254;
  localparam logic [7:0] C_DO       = 8'd253;
  localparam logic [7:0] C_WONT     = 8'd252;
  localparam logic [7:0] C_WILL     = 8'd251;
  localparam logic [7:0] C_DM       = 8'd242;
  localparam logic [7:0] C_NOP      = 8'd241;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] C_NUL      = 8'h00;
  localparam logic [7:0] C_BS       = 8'h08;
  localparam logic [7:0] C_LF       = 8'h0A;
  localparam logic [7:0] C_CR       = 8'h0D;
  localparam logic [7:0] C_SP       = 8'h20;
  localparam logic [7:0] C_DEL      = 8'h7F;
  localparam logic [7:0] C_PRINT_LO = 8'h20;
  localparam logic [7:0] C_PRINT_HI = 8'h7F;
  localparam logic [7:0] POS_MAX    = 8'd255;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_STORE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    ST_DATA = 7'b0000001,
    ST_CR   = 7'b0000010,
    ST_IAC  = 7'b0000100,
    ST_WILL = 7'b0001000,
    ST_WONT = 7'b0010000,
    ST_DO   = 7'b0100000,
    ST_DONT = 7'b1000000
  } pstate_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] store_index;
    logic       echo_negotiated;
    logic       suppress_go_ahead;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] store_index;
  } res_t;

  // One queue entry: up to MAX_RES results of one received byte
  typedef struct packed {
    res_t [MAX_RES-1:0]   res;
    logic [RES_IDX_W-1:0] last_idx;
    logic                 echo_flag;
    logic                 sga_flag;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] sat_inc(logic [7:0] p);
    sat_inc = (p == POS_MAX) ? p : 8'(p + 8'd1);
  endfunction

endpackage

FILE: src/telnet_option_line_parser.sv
// Telnet receive parser with option negotiation and line assembly.
// Results of an accepted byte are registered in the queue and drained by the back end.
// One byte per cycle is taken in while the queue is not full; the back end sends
// one result beat per cycle while out_stall_i is low, and a byte has at most 4 results.
// A two-entry queue lets input continue while earlier results drain.
// Reset (async, active low) clears parser, flags, position and queue; echo_always resets to 1.
`include "telnet_option_line_parser_assert.svh"

module telnet_option_line_parser #(
  parameter int LineSize   = tolp_pkg::LINE_SIZE,
  parameter int QueueDepth = tolp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tolp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tolp_pkg::out_item_t out_data_o
);

  logic              echo_always_q;
  logic              q_push, q_pop;
  tolp_pkg::entry_t  q_in, q_head;
  tolp_pkg::q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_always_q <= 1'b1;
    end else if (cfg_we_i) begin
      echo_always_q <= cfg_wdata_i;
    end
  end

  tolp_front #(
    .LineSize(LineSize)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .echo_always_i(echo_always_q),
    .q_stat_i     (q_stat),
    .push_o       (q_push),
    .entry_o      (q_in)
  );

  tolp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .head_o (q_head)
  );

  tolp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .head_i     (q_head),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  `TOLP_ASSERT_NOW(a_done_is_last, out_valid_o && out_data_o.kind == tolp_pkg::KIND_DONE, out_data_o.last, "line complete beat not last")
  `TOLP_ASSERT_NOW(a_store_in_line, out_valid_o && out_data_o.kind == tolp_pkg::KIND_STORE, out_data_o.store_index < 8'(LineSize), "store write beyond line size")
  `TOLP_ASSERT_NOW(a_tx_index_zero, out_valid_o && out_data_o.kind == tolp_pkg::KIND_TX, out_data_o.store_index == 8'd0, "transmit beat with nonzero index")
  `TOLP_ASSERT_NEXT(a_entry_drains, out_valid_o && !out_stall_i && !out_data_o.last, out_valid_o, "results of a byte cut short")

endmodule

FILE: src/tolp_front.sv
// Front end: accepts received bytes, runs the telnet parser and builds one
// queue entry with the first four results of the byte. Depends on tolp_pkg.
module tolp_front #(
  parameter int LineSize = tolp_pkg::LINE_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tolp_pkg::in_item_t in_data_i,
  input  logic              echo_always_i,
  input  tolp_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output tolp_pkg::entry_t  entry_o
);

  localparam logic [7:0] LineLimit = 8'(LineSize);

  tolp_pkg::pstate_e state_q, state_d;
  logic       echo_q, echo_d;
  logic       sga_q, sga_d;
  logic [7:0] pos_q, pos_d;

  tolp_pkg::res_t slot [tolp_pkg::NUM_SLOTS];
  logic [tolp_pkg::NUM_SLOTS-1:0] slot_en;

  logic       accept;
  logic       pre, do_data, crlf, opt_step;
  logic [7:0] pre_byte, p1, b, cmd;
  logic       echo_on, known, enable;
  logic [tolp_pkg::SLOT_CNT_W-1:0] rank;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    b        = in_data_i.rx_byte;
    echo_on  = echo_q || echo_always_i;
    known    = (b == tolp_pkg::OPT_ECHO) || (b == tolp_pkg::OPT_SGA);
    enable   = (state_q == tolp_pkg::ST_WILL) || (state_q == tolp_pkg::ST_DO);
    state_d  = state_q;
    echo_d   = echo_q;
    sga_d    = sga_q;
    pos_d    = pos_q;
    pre      = 1'b0;
    pre_byte = tolp_pkg::C_NUL;
    do_data  = 1'b0;
    crlf     = 1'b0;
    opt_step = 1'b0;
    cmd      = tolp_pkg::C_WONT;
    p1       = pos_q;
    slot_en  = '0;
    for (int i = 0; i < tolp_pkg::NUM_SLOTS; i++) begin
      slot[i] = '{kind: tolp_pkg::KIND_TX, out_byte: 8'd0, store_index: 8'd0};
    end

    case (state_q)
      tolp_pkg::ST_CR: begin
        state_d = tolp_pkg::ST_DATA;
        if (b == tolp_pkg::C_LF) begin
          crlf = 1'b1;
        end else begin
          pre      = 1'b1;
          pre_byte = tolp_pkg::C_CR;
          do_data  = (b != tolp_pkg::C_NUL);
        end
      end
      tolp_pkg::ST_IAC: begin
        state_d = tolp_pkg::ST_DATA;
        if (b == tolp_pkg::C_WILL) begin
          state_d = tolp_pkg::ST_WILL;
        end else if (b == tolp_pkg::C_WONT) begin
          state_d = tolp_pkg::ST_WONT;
        end else if (b == tolp_pkg::C_DO) begin
          state_d = tolp_pkg::ST_DO;
        end else if (b == tolp_pkg::C_DONT) begin
          state_d = tolp_pkg::ST_DONT;
        end else if (b == tolp_pkg::C_IAC) begin
          pre      = 1'b1;
          pre_byte = tolp_pkg::C_IAC;
        end else if (b != tolp_pkg::C_NOP && b != tolp_pkg::C_DM) begin
          do_data = 1'b1;
        end
      end
      tolp_pkg::ST_WILL, tolp_pkg::ST_WONT, tolp_pkg::ST_DO, tolp_pkg::ST_DONT: begin
        state_d  = tolp_pkg::ST_DATA;
        opt_step = 1'b1;
      end
      default: begin
        // data state; stray codes fall back here as well
        state_d = tolp_pkg::ST_DATA;
        do_data = 1'b1;
      end
    endcase

    // stored prefix byte: the CR of CR-x, or an escaped IAC
    if (pre) begin
      slot[0]    = '{kind: tolp_pkg::KIND_STORE, out_byte: pre_byte, store_index: pos_q};
      slot_en[0] = (pos_q < LineLimit);
      p1         = tolp_pkg::sat_inc(pos_q);
      pos_d      = p1;
    end

    if (crlf) begin
      slot[1]    = '{kind: tolp_pkg::KIND_STORE, out_byte: tolp_pkg::C_NUL, store_index: pos_q};
      slot_en[1] = (pos_q < LineLimit);
      pos_d      = tolp_pkg::sat_inc(pos_q);
      slot[5]    = '{kind: tolp_pkg::KIND_DONE, out_byte: tolp_pkg::C_NUL,
                     store_index: (pos_q >= tolp_pkg::POS_MAX - 8'd1) ?
                                  tolp_pkg::POS_MAX : pos_q};
      slot_en[5] = 1'b1;
    end

    if (do_data) begin
      if (b == tolp_pkg::C_IAC) begin
        state_d = tolp_pkg::ST_IAC;
      end else if (b == tolp_pkg::C_CR) begin
        state_d    = tolp_pkg::ST_CR;
        slot[2]    = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_LF, store_index: 8'd0};
        slot[3]    = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_CR, store_index: 8'd0};
        slot_en[2] = echo_on;
        slot_en[3] = echo_on;
      end else if (b == tolp_pkg::C_LF) begin
        slot[1]    = '{kind: tolp_pkg::KIND_STORE, out_byte: tolp_pkg::C_NUL, store_index: p1};
        slot_en[1] = (p1 < LineLimit);
        pos_d      = tolp_pkg::sat_inc(p1);
        slot[2]    = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_LF, store_index: 8'd0};
        slot[3]    = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_CR, store_index: 8'd0};
        slot_en[2] = echo_on;
        slot_en[3] = echo_on;
        slot[5]    = '{kind: tolp_pkg::KIND_DONE, out_byte: tolp_pkg::C_NUL, store_index: p1};
        slot_en[5] = 1'b1;
      end else if (b == tolp_pkg::C_BS || b == tolp_pkg::C_DEL) begin
        if (p1 != 8'd0) begin
          pos_d      = 8'(p1 - 8'd1);
          slot[2]    = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_SP, store_index: 8'd0};
          slot[3]    = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_BS, store_index: 8'd0};
          slot_en[2] = echo_on;
          slot_en[3] = echo_on;
        end
        slot[4]    = '{kind: tolp_pkg::KIND_TX, out_byte: b, store_index: 8'd0};
        slot_en[4] = (b == tolp_pkg::C_DEL) && echo_on;
      end else begin
        slot[1]    = '{kind: tolp_pkg::KIND_STORE, out_byte: b, store_index: p1};
        slot_en[1] = (p1 < LineLimit);
        pos_d      = tolp_pkg::sat_inc(p1);
        slot[4]    = '{kind: tolp_pkg::KIND_TX, out_byte: b, store_index: 8'd0};
        slot_en[4] = (b >= tolp_pkg::C_PRINT_LO) && (b <= tolp_pkg::C_PRINT_HI) && echo_on;
      end
    end

    if (opt_step) begin
      if (known) begin
        if (b == tolp_pkg::OPT_ECHO) begin
          echo_d = enable;
        end else begin
          sga_d = enable;
        end
      end
      case (state_q)
        tolp_pkg::ST_WILL: cmd = known ? tolp_pkg::C_DO : tolp_pkg::C_DONT;
        tolp_pkg::ST_DO:   cmd = known ? tolp_pkg::C_WILL : tolp_pkg::C_WONT;
        tolp_pkg::ST_WONT: cmd = tolp_pkg::C_DONT;
        default:           cmd = tolp_pkg::C_WONT;
      endcase
      slot[0] = '{kind: tolp_pkg::KIND_TX, out_byte: tolp_pkg::C_IAC, store_index: 8'd0};
      slot[1] = '{kind: tolp_pkg::KIND_TX, out_byte: cmd, store_index: 8'd0};
      slot[2] = '{kind: tolp_pkg::KIND_TX, out_byte: b, store_index: 8'd0};
      slot_en = '0;
      slot_en[2:0] = 3'b111;
    end

    // new line request: clear the position only, no results
    if (in_data_i.action) begin
      state_d = state_q;
      echo_d  = echo_q;
      sga_d   = sga_q;
      pos_d   = 8'd0;
      slot_en = '0;
    end
  end

  // Pack the enabled slots in order; anything past the fourth is dropped.
  always_comb begin
    entry_o = '0;
    rank    = '0;
    for (int i = 0; i < tolp_pkg::NUM_SLOTS; i++) begin
      if (slot_en[i]) begin
        if (rank < tolp_pkg::SLOT_CNT_W'(tolp_pkg::MAX_RES)) begin
          entry_o.res[rank[tolp_pkg::RES_IDX_W-1:0]] = slot[i];
        end
        rank = tolp_pkg::SLOT_CNT_W'(rank + 1'b1);
      end
    end
    entry_o.last_idx  = (rank >= tolp_pkg::SLOT_CNT_W'(tolp_pkg::MAX_RES)) ?
                        tolp_pkg::RES_IDX_W'(tolp_pkg::MAX_RES - 1) :
                        tolp_pkg::RES_IDX_W'(rank - 1'b1);
    entry_o.echo_flag = echo_d;
    entry_o.sga_flag  = sga_d;
  end

  assign push_o = accept && (rank != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tolp_pkg::ST_DATA;
      echo_q  <= 1'b0;
      sga_q   <= 1'b0;
      pos_q   <= 8'd0;
    end else if (accept) begin
      state_q <= state_d;
      echo_q  <= echo_d;
      sga_q   <= sga_d;
      pos_q   <= pos_d;
    end
  end

endmodule

FILE: src/tolp_queue.sv
// Short entry queue between parser front end and result back end.
// Depends on tolp_pkg.
module tolp_queue #(
  parameter int Depth = tolp_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tolp_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output tolp_pkg::q_stat_t stat_o,
  output tolp_pkg::entry_t  head_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  tolp_pkg::entry_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_next(logic [AW-1:0] p);
    ptr_next = (p == AW'(Depth - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = CW'(cnt_q + 1'b1);
      2'b01:   cnt_d = CW'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/tolp_back.sv
// Back end: walks the results of the queue head out one beat at a time.
// Depends on tolp_pkg.
module tolp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tolp_pkg::q_stat_t   q_stat_i,
  input  tolp_pkg::entry_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tolp_pkg::out_item_t out_data_o
);

  logic [tolp_pkg::RES_IDX_W-1:0] idx_q, idx_d;
  logic is_last, fire;

  assign out_valid_o = !q_stat_i.empty;
  assign is_last     = (idx_q == head_i.last_idx);
  assign fire        = out_valid_o && !out_stall_i;
  assign pop_o       = fire && is_last;

  assign out_data_o.kind              = head_i.res[idx_q].kind;
  assign out_data_o.out_byte          = head_i.res[idx_q].out_byte;
  assign out_data_o.store_index       = head_i.res[idx_q].store_index;
  assign out_data_o.echo_negotiated   = head_i.echo_flag;
  assign out_data_o.suppress_go_ahead = head_i.sga_flag;
  assign out_data_o.last              = is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      // advance within the entry, rewind when it is done
      idx_d = is_last ? '0 : tolp_pkg::RES_IDX_W'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
